// ===== hw/rtl/sm3_hash_engine_macros.svh =====
// assertion macros for the sm3 hash engine checker
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH
// implication checked at every clock edge outside reset
`define SM3_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define SM3_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== hw/rtl/sm3_pkg.sv =====
// shared types, constants and round functions of the sm3 hash engine
package sm3_pkg;
   localparam logic [31:0] IV [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
   } state_type;

   // control from sequencer to round core
   typedef struct packed {
      logic       init;
      logic       step;
      logic       fold;
      logic       reset_iv;
      logic [5:0] round;
   } core_ctl_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction
endpackage

// ===== hw/rtl/sm3_round_core.sv =====
// sm3 compression datapath: one round per cycle while step is asserted, window expansion, feed-forward
module sm3_round_core import sm3_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  core_ctl_type       ctl,
   input  logic [31:0]        blk [16],
   output logic [31:0]        cv  [8]
);
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [31:0] cv_ff [8];
   logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, nw;
   logic        lo;

   // round function
   always_comb begin
      lo  = (ctl.round < 6'd16);
      tj  = lo ? T_LOW : T_HIGH;
      a12 = rotl(v_ff[0], 5'd12);
      ss1 = rotl(a12 + v_ff[4] + rotl(tj, ctl.round[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      ff  = lo ? (v_ff[0] ^ v_ff[1] ^ v_ff[2])
               : ((v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]));
      gg  = lo ? (v_ff[4] ^ v_ff[5] ^ v_ff[6]) : ((v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]));
      tt1 = ff + v_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = gg + v_ff[7] + ss1 + w_ff[0];
      nw  = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15)) ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];
   end

   // working variables and expansion window
   always_ff @(posedge clock) begin
      if (ctl.init) begin
         v_ff <= cv_ff;
         w_ff <= blk;
      end else if (ctl.step) begin
         v_ff <= '{tt1, v_ff[0], rotl(v_ff[1], 5'd9), v_ff[2],
                   perm0(tt2), v_ff[4], rotl(v_ff[5], 5'd19), v_ff[6]};
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= nw;
      end
   end

   // chaining value
   always_ff @(posedge clock) begin
      if (reset || ctl.reset_iv) begin
         cv_ff <= IV;
      end else if (ctl.fold) begin
         for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] ^ v_ff[i];
      end
   end

   assign cv = cv_ff;
endmodule

// ===== hw/rtl/sm3_hash_engine.sv =====
// sm3 hash engine top level: word intake, padding sequencer and digest output
// a non-final word is written to the block store; when it completes a block it also starts a compression (64 rounds)
// a final word is followed by padding words and one or two compressions,
// then eight digest beats; throughput is set by the single shared round unit
// synchronous active-high reset restores the iv and clears length and counters
module sm3_hash_engine import sm3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_end
);
   state_type    state_ff, state_in;
   logic [31:0]  blk_ff [16];
   logic [3:0]   pos_ff, pos_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic [60:0]  bytes_ff, bytes_in;
   logic         fin_ff, fin_in;      // padding pending for final message
   logic         lenw_ff, lenw_in;    // pad byte already placed in the block
   logic         lenhi_ff, lenhi_in;  // high length word already in the block
   logic [2:0]   oidx_ff, oidx_in;
   logic         wr;
   logic [31:0]  wdata;
   logic [31:0]  cv [8];
   logic [63:0]  bits;
   logic [2:0]   k;
   logic [31:0]  keep, padw;
   core_ctl_type ctl;

   sm3_round_core u_core (.clock(clock), .reset(reset), .ctl(ctl), .blk(blk_ff), .cv(cv));

   assign bits = {bytes_ff, 3'b000};
   assign k    = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         rnd_ff   <= '0;
         bytes_ff <= '0;
         fin_ff   <= 1'b0;
         lenw_ff  <= 1'b0;
         lenhi_ff <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         bytes_ff <= bytes_in;
         fin_ff   <= fin_in;
         lenw_ff  <= lenw_in;
         lenhi_ff <= lenhi_in;
         oidx_ff  <= oidx_in;
      end
   end

   // block word store
   always_ff @(posedge clock) begin
      if (wr) blk_ff[pos_ff] <= wdata;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      bytes_in = bytes_ff;
      fin_in   = fin_ff;
      lenw_in  = lenw_ff;
      lenhi_in = lenhi_ff;
      oidx_in  = oidx_ff;
      wr       = 1'b0;
      wdata    = '0;
      ctl      = '0;
      ctl.round = rnd_ff;
      req_ready = 1'b0;
      keep = (k == 3'd0) ? 32'h0 : ~(32'hFFFFFFFF >> {k, 3'b000});
      padw = (req_message_word & keep) | ({24'h0, PAD_BYTE} << (6'd24 - {k, 3'b000}));
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               wr = 1'b1;
               pos_in = pos_ff + 4'd1;
               if (!req_final_word) begin
                  wdata = req_message_word;
                  bytes_in = bytes_ff + 61'd4;
               end else begin
                  bytes_in = bytes_ff + {58'd0, k};
                  fin_in = 1'b1;
                  lenw_in = 1'b1;
                  // four valid bytes: pad byte goes into the next word
                  wdata = (k == 3'd4) ? req_message_word : padw;
                  lenw_in = (k != 3'd4);
               end
               if (pos_ff == 4'd15) state_in = ST_LOAD;
               else if (req_final_word) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // lenw_ff low: pad word 0x80000000 still owed
            // slot 15 without the high length word, once the pad word is in, is zero fill before an extra block
            wr = 1'b1;
            pos_in = pos_ff + 4'd1;
            if (!lenw_ff) begin
               wdata = {PAD_BYTE, 24'h0};
               lenw_in = 1'b1;
            end else if (pos_ff == 4'd14) begin
               wdata = bits[63:32];
               lenhi_in = 1'b1;
            end else if (pos_ff == 4'd15 && lenhi_ff) begin
               wdata = bits[31:0];
               fin_in = 1'b0;
               lenhi_in = 1'b0;
            end
            if (pos_ff == 4'd15) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.init = 1'b1;
            rnd_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.step = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            if (fin_ff) state_in = ST_PAD;
            else if (lenw_ff) begin
               state_in = ST_OUT;
               oidx_in = '0;
            end else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  ctl.reset_iv = 1'b1;
                  bytes_in = '0;
                  lenw_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = cv[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_digest_end  = (oidx_ff == 3'd7);
endmodule

// ===== hw/rtl/sm3_checker.sv =====
// port-level checker for the sm3 hash engine, bound to the top level
`include "sm3_hash_engine_macros.svh"
module sm3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic       rsp_digest_end
);
   `SM3_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "input taken during digest")
   `SM3_ASSERT_IMP(a_end_idx, clock, reset, rsp_valid, rsp_digest_end == (rsp_word_index == 3'd7), "end flag mismatch")
   `SM3_ASSERT_NEXT(a_idx_step, clock, reset, rsp_valid && rsp_ready && !rsp_digest_end, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1, "digest index skipped")
   `SM3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word_index), "digest beat dropped")
endmodule

bind sm3_hash_engine sm3_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word_index(rsp_word_index),
   .rsp_digest_end(rsp_digest_end)
);
